FILE: rtl/core/vlfd_pkg.sv
// Shared constants, types and codes for the variable-length frame deframer.
package vlfd_pkg;

   localparam int BANK_DEPTH     = 256;
   localparam int MAX_BLOCKS     = 15;
   localparam int COUNT_POSITION = 5;

   localparam int POS_W  = $clog2(BANK_DEPTH);
   localparam int ADDR_W = POS_W + 1;
   localparam int LEN_W  = $clog2(BANK_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_W  = LEN_W + CNT_W + 1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      HUNT_FIRST  = 2'd0,
      HUNT_SECOND = 2'd1,
      HUNT_HEADER = 2'd2,
      HUNT_BODY   = 2'd3
   } hunt_type;

   localparam logic [1:0] CSR_SYNC_FIRST    = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND   = 2'd1;
   localparam logic [1:0] CSR_HEADER_LENGTH = 2'd2;
   localparam logic [1:0] CSR_BLOCK_LENGTH  = 2'd3;

   typedef struct packed {
      logic        frame_done;
      logic [8:0]  frame_length;
      logic        frame_pending;
      logic [31:0] frames_received;
      logic [31:0] frames_lost;
      logic        rd_hit;
   } vlfd_stat_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } vlfd_mem_req_type;

endpackage

FILE: rtl/core/vlfd_store.sv
// Two-bank frame store: one write port, one read port with registered read data.
module vlfd_store (
   input  logic                      clock,
   input  vlfd_pkg::vlfd_mem_req_type mem_req,
   output logic [7:0]                rd_data
);
   import vlfd_pkg::*;

   logic [7:0] mem_ff [2*BANK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/vlfd_parse.sv
// Sync hunt, length decode, bank swap, pending flag and frame counters.
module vlfd_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_take,
   input  logic [1:0]                 kind,
   input  logic [7:0]                 rx_byte,
   input  logic [7:0]                 read_index,
   input  logic                       csr_take,
   input  logic [1:0]                 csr_index,
   input  logic [7:0]                 csr_data,
   output vlfd_pkg::vlfd_stat_type    stat,
   output vlfd_pkg::vlfd_mem_req_type mem_req
);
   import vlfd_pkg::*;

   logic [7:0]       sync_first_ff, sync_second_ff;
   logic [4:0]       header_length_ff;
   logic [3:0]       block_length_ff;

   hunt_type         hunt_ff, hunt_in;
   logic [LEN_W-1:0] taken_ff, taken_in;
   logic [LEN_W-1:0] expect_ff, expect_in;
   logic             bank_ff, bank_in;
   logic [LEN_W-1:0] ready_len_ff, ready_len_in;
   logic             pending_ff, pending_in;
   logic [31:0]      received_ff, received_in;
   logic [31:0]      lost_ff, lost_in;

   logic             done;
   logic             wr_en;
   logic [LEN_W-1:0] wr_pos;
   logic [LEN_W-1:0] taken_inc;
   logic [SUM_W-1:0] calc_len;
   logic [LEN_W-1:0] body_len;
   logic             rd_hit;
   kind_type         kind_code;

   assign kind_code = kind_type'(kind);
   assign taken_inc = taken_ff + LEN_W'(1);
   assign calc_len  = SUM_W'(header_length_ff)
                    + SUM_W'(rx_byte[CNT_W-1:0]) * SUM_W'(block_length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff    <= 8'd170;
         sync_second_ff   <= 8'd85;
         header_length_ff <= 5'd6;
         block_length_ff  <= 4'd15;
      end else if (csr_take) begin
         case (csr_index)
            CSR_SYNC_FIRST:    sync_first_ff    <= csr_data;
            CSR_SYNC_SECOND:   sync_second_ff   <= csr_data;
            CSR_HEADER_LENGTH: header_length_ff <= csr_data[4:0];
            CSR_BLOCK_LENGTH:  block_length_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      hunt_in      = hunt_ff;
      taken_in     = taken_ff;
      expect_in    = expect_ff;
      bank_in      = bank_ff;
      ready_len_in = ready_len_ff;
      pending_in   = pending_ff;
      received_in  = received_ff;
      lost_in      = lost_ff;
      done         = 1'b0;
      wr_en        = 1'b0;
      wr_pos       = taken_ff;
      body_len     = expect_ff;
      rd_hit       = 1'b0;
      case (kind_code)
         KIND_BYTE: begin
            if (hunt_ff == HUNT_SECOND && rx_byte == sync_second_ff) begin
               wr_en    = 1'b1;
               wr_pos   = LEN_W'(1);
               taken_in = LEN_W'(2);
               hunt_in  = HUNT_HEADER;
            end else if (hunt_ff == HUNT_FIRST || hunt_ff == HUNT_SECOND) begin
               // broken sync falls back to a fresh hunt on the same byte
               hunt_in   = HUNT_FIRST;
               taken_in  = '0;
               expect_in = '0;
               if (rx_byte == sync_first_ff) begin
                  wr_en    = 1'b1;
                  wr_pos   = '0;
                  taken_in = LEN_W'(1);
                  hunt_in  = HUNT_SECOND;
               end
            end else begin
               wr_en    = 1'b1;
               wr_pos   = taken_ff;
               taken_in = taken_inc;
               if (hunt_ff == HUNT_HEADER) begin
                  if (taken_inc < LEN_W'(COUNT_POSITION + 1)) begin
                     body_len = '0;
                  end else if (rx_byte > 8'(MAX_BLOCKS)
                               || calc_len > SUM_W'(BANK_DEPTH)) begin
                     hunt_in  = HUNT_FIRST;
                     taken_in = '0;
                     body_len = '0;
                  end else begin
                     hunt_in = HUNT_BODY;
                     if (LEN_W'(calc_len) < taken_inc) begin
                        body_len = taken_inc;
                     end else begin
                        body_len = LEN_W'(calc_len);
                     end
                  end
                  expect_in = body_len;
               end
               if (hunt_in == HUNT_BODY && taken_inc >= body_len) begin
                  done         = 1'b1;
                  received_in  = received_ff + 32'd1;
                  if (pending_ff) begin
                     lost_in = lost_ff + 32'd1;
                  end
                  pending_in   = 1'b1;
                  ready_len_in = body_len;
                  bank_in      = ~bank_ff;
                  hunt_in      = HUNT_FIRST;
                  taken_in     = '0;
                  expect_in    = '0;
               end
            end
         end
         KIND_ACK: begin
            pending_in = 1'b0;
         end
         KIND_READ: begin
            rd_hit = (LEN_W'(read_index) < ready_len_ff)
                   && ((LEN_W + 8)'(read_index) < (LEN_W + 8)'(BANK_DEPTH));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff      <= HUNT_FIRST;
         taken_ff     <= '0;
         expect_ff    <= '0;
         bank_ff      <= 1'b0;
         ready_len_ff <= '0;
         pending_ff   <= 1'b0;
         received_ff  <= '0;
         lost_ff      <= '0;
      end else if (item_take) begin
         hunt_ff      <= hunt_in;
         taken_ff     <= taken_in;
         expect_ff    <= expect_in;
         bank_ff      <= bank_in;
         ready_len_ff <= ready_len_in;
         pending_ff   <= pending_in;
         received_ff  <= received_in;
         lost_ff      <= lost_in;
      end
   end

   assign mem_req.wr_en   = item_take && wr_en && (wr_pos < LEN_W'(BANK_DEPTH));
   assign mem_req.wr_addr = {bank_ff, wr_pos[POS_W-1:0]};
   assign mem_req.wr_data = rx_byte;
   assign mem_req.rd_en   = item_take && rd_hit;
   assign mem_req.rd_addr = {~bank_ff, POS_W'(read_index)};

   assign stat.frame_done      = done;
   assign stat.frame_length    = 9'(ready_len_in);
   assign stat.frame_pending   = pending_in;
   assign stat.frames_received = received_in;
   assign stat.frames_lost     = lost_in;
   assign stat.rd_hit          = rd_hit;

endmodule

FILE: rtl/core/variable_length_frame_deframer.sv
// Variable-length frame deframer: top level with the store read stage and output register.
//
// req_ (stream in): one request per cycle while req_tready is high; tuser holds
// the kind (received byte, acknowledge, read stored byte), tdata rx_byte and read_index.
// rsp_ (stream out): exactly one response per request, in order, with the frame
// status after that request and, for a read, the stored byte of the ready frame.
// csr_: register writes (sync bytes, header length, block length); always ready,
// to be used only while no request is in flight.
// Path: parse writes or reads the store and registers the status in the read stage;
// the output register then takes status and read byte and drives rsp_.
// Throughput: one request per cycle while rsp_ is not stalled; every stage then works
// on a fresh request each cycle; the frame store takes one write and one read per cycle.
// A stalled response holds the output register; the read stage then holds too
// and req_tready drops until the response is taken.
// Reset (synchronous, active high) clears hunt state, bank select, pending flag,
// both frame counters and the registers to their defaults; the store is not
// cleared, and only bytes of a completed frame are ever read back.
module variable_length_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] rx_byte, [15:8] read_index
   input  logic [vlfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] frame_done, [9:1] frame_length, [10] frame_pending,
   // [42:11] frames_received, [74:43] frames_lost, [82:75] read_data, [87:83] zero
   output logic [vlfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [7:0]                        csr_data
);
   import vlfd_pkg::*;

   vlfd_stat_type              stat;
   vlfd_mem_req_type           mem_req;
   logic [7:0]                 rd_data;
   logic                       req_take;
   logic                       s1_move;

   logic                       s1_valid_ff;
   vlfd_stat_type              s1_stat_ff;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   assign csr_ready  = 1'b1;
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_take   = req_tvalid && req_tready;

   vlfd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_take  (req_take),
      .kind       (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .read_index (req_tdata[15:8]),
      .csr_take   (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .stat       (stat),
      .mem_req    (mem_req)
   );

   vlfd_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_stat_ff <= stat;
      end
   end

   assign rsp_data_in = {5'd0,
                         s1_stat_ff.rd_hit ? rd_data : 8'd0,
                         s1_stat_ff.frames_lost,
                         s1_stat_ff.frames_received,
                         s1_stat_ff.frame_pending,
                         s1_stat_ff.frame_length,
                         s1_stat_ff.frame_done};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
